// ===== rtl/core/cles_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cles_pkg;

   // field widths
   localparam int CMD_W   = 2;
   localparam int LINE_W  = 2;
   localparam int COL_W   = 6;
   localparam int CHAR_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 7;
   localparam int SHIFT_W = 3;
   localparam int WAIT_W  = 13;
   localparam int INDEX_W = 2;
   localparam int STEP_W  = 5;

   // register reset values
   localparam logic [ADDR_W-1:0]  ADDR_RESET  = 7'h27;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd4;
   localparam logic [BYTE_W-1:0]  MASK_RESET  = 8'h08;

   // expander pin bits
   localparam logic [BYTE_W-1:0] BIT_RS = 8'h01;
   localparam logic [BYTE_W-1:0] BIT_EN = 8'h04;

   // lcd command bytes and cursor addressing
   localparam logic [BYTE_W-1:0] LCD_CLR_DISPLAY = 8'h01;
   localparam logic [BYTE_W-1:0] LCD_SET_DDRAM   = 8'h80;
   localparam logic [BYTE_W-1:0] LCD_ROW_OFFSET  = 8'h40;

   // waits in microseconds
   localparam logic [WAIT_W-1:0] WAIT_EN_HIGH = 13'd1;
   localparam logic [WAIT_W-1:0] WAIT_EN_LOW  = 13'd50;

   // step of the final write of each job kind
   localparam logic [STEP_W-1:0] INIT_LAST = 5'd23;
   localparam logic [STEP_W-1:0] BYTE_LAST = 5'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT       = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_SET_CURSOR = 2'd2,
      CMD_WRITE_CHAR = 2'd3
   } cmd_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_ADDRESS   = 2'd0,
      REG_SHIFT     = 2'd1,
      REG_BACKLIGHT = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      EXTRA_NONE = 2'd0,
      EXTRA_150  = 2'd1,
      EXTRA_2000 = 2'd2,
      EXTRA_5000 = 2'd3
   } extra_type;

   // one queued job: init sequence, or one lcd byte
   typedef struct packed {
      logic               is_init;
      logic [BYTE_W-1:0]  value;
      logic               rs;
      logic               long_wait;
   } job_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [SHIFT_W-1:0] shift;
      logic [BYTE_W-1:0]  mask;
   } cfg_type;

   typedef struct packed {
      logic [3:0] nib;
      extra_type  extra;
   } nib_entry_type;

   // init sequence rom: reset nibbles, then 0x28, 0x0C, 0x01, 0x06 as nibble pairs
   function automatic nib_entry_type init_nibble(input logic [3:0] idx);
      nib_entry_type e;
      e = '{nib: 4'h0, extra: EXTRA_NONE};
      unique case (idx)
         4'd0:    e = '{nib: 4'h3, extra: EXTRA_5000};
         4'd1:    e = '{nib: 4'h3, extra: EXTRA_150};
         4'd2:    e = '{nib: 4'h3, extra: EXTRA_150};
         4'd3:    e = '{nib: 4'h2, extra: EXTRA_150};
         4'd4:    e = '{nib: 4'h2, extra: EXTRA_NONE};
         4'd5:    e = '{nib: 4'h8, extra: EXTRA_NONE};
         4'd6:    e = '{nib: 4'h0, extra: EXTRA_NONE};
         4'd7:    e = '{nib: 4'hC, extra: EXTRA_NONE};
         4'd8:    e = '{nib: 4'h0, extra: EXTRA_NONE};
         4'd9:    e = '{nib: 4'h1, extra: EXTRA_2000};
         4'd10:   e = '{nib: 4'h0, extra: EXTRA_NONE};
         4'd11:   e = '{nib: 4'h6, extra: EXTRA_NONE};
         default: e = '{nib: 4'h0, extra: EXTRA_NONE};
      endcase
      return e;
   endfunction

   function automatic logic [WAIT_W-1:0] extra_us(input extra_type x);
      logic [WAIT_W-1:0] us;
      us = '0;
      unique case (x)
         EXTRA_NONE: us = 13'd0;
         EXTRA_150:  us = 13'd150;
         EXTRA_2000: us = 13'd2000;
         EXTRA_5000: us = 13'd5000;
         default:    us = 13'd0;
      endcase
      return us;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cles_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// lcd command channel
interface cles_req_if;
   logic                          valid;
   logic                          ready;
   logic [cles_pkg::CMD_W-1:0]    cmd;
   logic [cles_pkg::LINE_W-1:0]   line;
   logic [cles_pkg::COL_W-1:0]    column;
   logic [cles_pkg::CHAR_W-1:0]   character_code;

   modport source (output valid, output cmd, output line, output column,
                   output character_code, input ready);
   modport sink   (input valid, input cmd, input line, input column,
                   input character_code, output ready);
endinterface

// expander write channel
interface cles_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cles_pkg::BYTE_W-1:0]   expander_byte;
   logic [cles_pkg::ADDR_W-1:0]   device_address;
   logic [cles_pkg::WAIT_W-1:0]   wait_us;
   logic                          last;

   modport source (output valid, output expander_byte, output device_address,
                   output wait_us, output last, input ready);
   modport sink   (input valid, input expander_byte, input device_address,
                   input wait_us, input last, output ready);
endinterface

// register write channel
interface cles_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cles_pkg::INDEX_W-1:0]  index;
   logic [cles_pkg::BYTE_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cles_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cles_front (
   input  wire logic            clock,
   input  wire logic            reset,
   cles_req_if.sink             req_bus,
   input  wire logic            queue_full,
   output logic                 push_valid,
   output cles_pkg::job_type    push_job,
   output logic                 initialized
);
   import cles_pkg::*;

   logic initialized_ff;
   logic initialized_in;
   logic accept;
   logic [BYTE_W-1:0] cursor_sum;
   logic [BYTE_W-1:0] row_offset;

   assign req_bus.ready = ~queue_full;
   assign accept        = req_bus.valid & ~queue_full;
   assign initialized   = initialized_ff;

   // cursor address: line above one selects the second row
   assign row_offset = (req_bus.line > 2'd1) ? LCD_ROW_OFFSET : '0;
   assign cursor_sum = BYTE_W'({2'b00, req_bus.column}) + row_offset;

   // classify the command into a job
   always_comb begin
      push_job = '{is_init: 1'b0, value: '0, rs: 1'b0, long_wait: 1'b0};
      unique case (cmd_type'(req_bus.cmd))
         CMD_INIT:       push_job.is_init = 1'b1;
         CMD_CLEAR: begin
            push_job.value     = LCD_CLR_DISPLAY;
            push_job.long_wait = 1'b1;
         end
         CMD_SET_CURSOR: push_job.value = LCD_SET_DDRAM | cursor_sum;
         CMD_WRITE_CHAR: begin
            push_job.value = req_bus.character_code;
            push_job.rs    = 1'b1;
         end
         default:        push_job.is_init = 1'b0;
      endcase
   end

   // commands before init are dropped
   assign push_valid = accept &
                       ((cmd_type'(req_bus.cmd) == CMD_INIT) | initialized_ff);
   assign initialized_in = initialized_ff |
                           (accept & (cmd_type'(req_bus.cmd) == CMD_INIT));

   always_ff @(posedge clock) begin
      if (reset) begin
         initialized_ff <= 1'b0;
      end else begin
         initialized_ff <= initialized_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cles_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cles_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cles_pkg::job_type   push_job,
   input  wire logic                pop,
   output cles_pkg::job_type        head_job,
   output logic                     empty,
   output logic                     full
);
   import cles_pkg::*;

   job_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign head_job = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cles_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cles_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cles_pkg::cfg_type   cfg,
   input  wire cles_pkg::job_type   head_job,
   input  wire logic                empty,
   output logic                     pop,
   cles_rsp_if.source               rsp_bus
);
   import cles_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic [WAIT_W-1:0] wait_in;
   logic              last_ff;
   logic              last_in;

   nib_entry_type     rom_entry;
   logic [3:0]        nib;
   extra_type         extra;
   logic              en_phase;
   logic [BYTE_W-1:0] data;
   logic              load;

   assign load = ~empty & (~valid_ff | rsp_bus.ready);
   assign pop  = load & last_in;

   // build the current expander write
   always_comb begin
      rom_entry = init_nibble(step_ff[STEP_W-1:1]);
      if (head_job.is_init) begin
         nib     = rom_entry.nib;
         extra   = rom_entry.extra;
         last_in = (step_ff == INIT_LAST);
      end else begin
         nib     = step_ff[1] ? head_job.value[3:0] : head_job.value[7:4];
         extra   = (step_ff[1] & head_job.long_wait) ? EXTRA_2000 : EXTRA_NONE;
         last_in = (step_ff == BYTE_LAST);
      end
      en_phase = ~step_ff[0];
      data     = (BYTE_W'({4'b0000, nib}) << cfg.shift) |
                 (head_job.rs ? BIT_RS : '0) | cfg.mask;
      byte_in  = en_phase ? (data | BIT_EN) : (data & ~BIT_EN);
      wait_in  = en_phase ? WAIT_EN_HIGH : (WAIT_EN_LOW + extra_us(extra));
   end

   // step counter and output valid
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = last_in ? '0 : step_ff + STEP_W'(1);
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         addr_ff <= cfg.address;
         wait_ff <= wait_in;
         last_ff <= last_in;
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.expander_byte  = byte_ff;
   assign rsp_bus.device_address = addr_ff;
   assign rsp_bus.wait_us        = wait_ff;
   assign rsp_bus.last           = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_expander_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Turns LCD commands (init, clear, set cursor, write character) into the
// expander byte writes that drive a 4-bit HD44780-style display through an
// I2C port expander; each result is one write with its address and the wait
// that must follow it. The back sequencer emits one write per clock while rsp
// takes every beat; a clear, set-cursor or character command is 4 writes
// and init is 24 writes; the step counter of that sequencer sets the rate. The
// front accepts and classifies commands into a two-entry job queue whose head
// is the job the sequencer works on, so one further command can be taken
// while the sequencer is busy; a full queue stalls req.
// Commands other than init are dropped without results until init has been
// accepted. Registers written on csr take effect on the next command and are
// to be written only while the block is idle; csr is always ready.

module char_lcd_expander_sequencer_core (
   input  wire logic   clock,
   input  wire logic   reset,
   cles_req_if.sink    req_bus,
   cles_rsp_if.source  rsp_bus,
   cles_csr_if.sink    csr_bus
);
   import cles_pkg::*;

   logic [ADDR_W-1:0]  address_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [BYTE_W-1:0]  mask_ff;
   cfg_type            cfg;

   logic    push_valid;
   job_type push_job;
   job_type head_job;
   logic    queue_empty;
   logic    queue_full;
   logic    pop;
   logic    initialized;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ADDR_RESET;
         shift_ff   <= SHIFT_RESET;
         mask_ff    <= MASK_RESET;
      end else if (csr_bus.valid) begin
         unique case (reg_type'(csr_bus.index))
            REG_ADDRESS:   address_ff <= csr_bus.data[ADDR_W-1:0];
            REG_SHIFT:     shift_ff   <= csr_bus.data[SHIFT_W-1:0];
            REG_BACKLIGHT: mask_ff    <= csr_bus.data;
            default:       mask_ff    <= mask_ff;
         endcase
      end
   end

   assign cfg = '{address: address_ff, shift: shift_ff, mask: mask_ff};

   cles_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .initialized (initialized)
   );

   cles_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   cles_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head_job (head_job),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

   // no write goes out before init has been accepted
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> initialized)
      else $error("expander write before init");

   // the enable-high write always carries EN and the short wait
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.wait_us == WAIT_EN_HIGH) |->
         (rsp_bus.expander_byte[2] && !rsp_bus.last))
      else $error("enable-high write malformed");

   // enable-low writes clear EN and wait at least the base time
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.wait_us != WAIT_EN_HIGH) |->
         (!rsp_bus.expander_byte[2] && rsp_bus.wait_us >= WAIT_EN_LOW))
      else $error("enable-low write malformed");

   // the queue never takes a job while full
   assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push_valid)
      else $error("job pushed into full queue");

endmodule

`default_nettype wire
